### rtl/core/scb_pkg.sv
// Shared types and constants for the statistics counter bank.
package scb_pkg;

	// Operation codes carried in the low bits of the input tuser
	localparam logic [2:0] FN_ADD    = 3'd0;
	localparam logic [2:0] FN_SET    = 3'd1;
	localparam logic [2:0] FN_MAX    = 3'd2;
	localparam logic [2:0] FN_AVG    = 3'd3;
	localparam logic [2:0] FN_CLR1   = 3'd4;
	localparam logic [2:0] FN_CLRALL = 3'd5;
	localparam logic [2:0] FN_READ   = 3'd6;

	localparam int unsigned IDX_W = 6;
	localparam int unsigned VAL_W = 64;
	localparam int unsigned CNT_W = 32;

	// Write request from the sequencer to the storage bank
	typedef struct packed {
		logic             val_we;
		logic             cnt_we;
		logic             clr_all;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
		logic [CNT_W-1:0] cnt;
	} scb_wr_t;

endpackage

### rtl/core/scb_div.sv
// Iterative unsigned 64 by 32 divider, one quotient bit per cycle.
module scb_div
	import scb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VAL_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [VAL_W-1:0] quotient
);

	localparam int unsigned STEP_W = $clog2(VAL_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  div_q;
	logic [CNT_W-1:0]  rem_q;
	logic [VAL_W-1:0]  quo_q;
	logic [CNT_W:0]    shifted;
	logic [CNT_W:0]    diff;
	logic              ge;

	// Shift in the next dividend bit and trial-subtract the divisor
	always_comb begin
		shifted = {rem_q, quo_q[VAL_W-1]};
		diff    = shifted - {1'b0, div_q};
		ge      = (shifted >= {1'b0, div_q});
	end

	// Control: count steps and flag the cycle after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(VAL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
			quo_q <= {quo_q[VAL_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider did not go busy after start");

endmodule

### rtl/core/scb_bank.sv
// Storage bank: statistic values and mean counts with per-entry valid bits.
module scb_bank
	import scb_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [VAL_W-1:0] rd_val,
	output logic [CNT_W-1:0] rd_cnt,
	input  scb_wr_t          wr
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [VAL_W-1:0] val_mem [DEPTH];
	logic [CNT_W-1:0] cnt_mem [DEPTH];
	logic [DEPTH-1:0] vvld_q;
	logic [DEPTH-1:0] cvld_q;
	logic [VAL_W-1:0] val_rd_q;
	logic [CNT_W-1:0] cnt_rd_q;
	logic             vvld_rd_q;
	logic             cvld_rd_q;
	logic [AW-1:0]    rd_a;
	logic [AW-1:0]    wr_a;

	assign rd_a = rd_idx[AW-1:0];
	assign wr_a = wr.idx[AW-1:0];

	// Valid bits: an invalid value reads as zero, an invalid count as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vvld_q    <= '0;
			cvld_q    <= '0;
			vvld_rd_q <= 1'b0;
			cvld_rd_q <= 1'b0;
		end else begin
			if (wr.clr_all) begin
				vvld_q <= '0;
			end else if (wr.val_we) begin
				vvld_q[wr_a] <= 1'b1;
			end
			if (wr.cnt_we) begin
				cvld_q[wr_a] <= 1'b1;
			end
			if (rd_en) begin
				vvld_rd_q <= vvld_q[rd_a];
				cvld_rd_q <= cvld_q[rd_a];
			end
		end
	end

	// Memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (wr.val_we) begin
			val_mem[wr_a] <= wr.val;
		end
		if (wr.cnt_we) begin
			cnt_mem[wr_a] <= wr.cnt;
		end
		if (rd_en) begin
			val_rd_q <= val_mem[rd_a];
			cnt_rd_q <= cnt_mem[rd_a];
		end
	end

	assign rd_val = vvld_rd_q ? val_rd_q : '0;
	assign rd_cnt = cvld_rd_q ? cnt_rd_q : CNT_W'(1);

	a_clr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		wr.clr_all |-> !wr.val_we)
		else $error("clear all collides with a value write");
	a_clr_done: assert property (@(posedge clk) disable iff (!arst_n)
		wr.clr_all |=> (vvld_q == '0))
		else $error("clear all left a valid value");

endmodule

### rtl/core/statistics_counter_bank_core.sv
// Top level: sequencer for the statistics counter bank with running mean.
//
//  channel   direction  fields
//  s_axis    in         tuser = func, stat_index; tdata = operand
//  m_axis    out        tdata = stat_value
//
//  Add, set, max, clear one, clear all, read: accept, then read, execute and output load.
//  Average (index in range): accept, then read, execute, magnitude, bit-serial divider,
//  divider done, final add/subtract and output load.
//  One transaction in flight; s_axis_tready is high only in idle, so a new one is taken only
//  once the last is done. A waiting result in the output register stalls only the sequencer.
//  Reset is immediate: valid bits make all values zero and all counts one.
module statistics_counter_bank_core
	import scb_pkg::*;
#(
	parameter int unsigned NUM_STATS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] operand
	input  logic [8:0]  s_axis_tuser,   // [2:0] func, [8:3] stat_index
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata    // [63:0] stat_value
);

	localparam int unsigned DEPTH = (NUM_STATS > 64) ? 64 : NUM_STATS;
	localparam logic [IDX_W:0] IdxLim = (IDX_W + 1)'(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_EXEC,
		ST_MAG,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

	state_t           state_q;
	logic [2:0]       func_q;
	logic [IDX_W-1:0] idx_q;
	logic [VAL_W-1:0] opnd_q;
	logic [VAL_W-1:0] v_q;
	logic [CNT_W-1:0] c_q;
	logic [VAL_W-1:0] diff_q;
	logic [VAL_W-1:0] res_q;
	logic             out_vld_q;
	logic [VAL_W-1:0] out_data_q;

	logic             s_acc;
	logic             out_free;
	logic             in_range;
	logic [VAL_W-1:0] rd_val;
	logic [CNT_W-1:0] rd_cnt;
	logic [VAL_W-1:0] exec_val;
	logic [VAL_W-1:0] fin_val;
	logic [CNT_W-1:0] cnt_inc;
	logic [VAL_W-1:0] mag;
	logic [CNT_W-1:0] divisor;
	logic             div_start;
	logic             div_busy;
	logic             div_done;
	logic [VAL_W-1:0] quotient;
	scb_wr_t          wr;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;
	assign in_range      = ({1'b0, idx_q} < IdxLim);

	// Execute the combinational operations on the value just read
	always_comb begin
		unique case (func_q)
			FN_ADD:  exec_val = rd_val + opnd_q;
			FN_SET:  exec_val = opnd_q;
			FN_MAX:  exec_val = ($signed(rd_val) < $signed(opnd_q)) ? opnd_q : rd_val;
			FN_CLR1: exec_val = '0;
			default: exec_val = rd_val;
		endcase
	end

	// Average: magnitude of the difference, then signed correction
	assign mag       = diff_q[VAL_W-1] ? (VAL_W'(0) - diff_q) : diff_q;
	assign divisor   = (c_q == '0) ? CNT_W'(1) : c_q;
	assign div_start = (state_q == ST_MAG);
	assign fin_val   = diff_q[VAL_W-1] ? (v_q - quotient) : (v_q + quotient);
	assign cnt_inc   = ((c_q + 1'b1) == '0) ? CNT_W'(1) : (c_q + 1'b1);

	// Bank write requests
	always_comb begin
		wr         = '0;
		wr.idx     = idx_q;
		if (state_q == ST_EXEC) begin
			wr.val = exec_val;
			if (func_q == FN_CLRALL) begin
				wr.clr_all = 1'b1;
			end else if (in_range && func_q != FN_AVG) begin
				wr.val_we = 1'b1;
			end
		end else if (state_q == ST_FIN) begin
			wr.val    = fin_val;
			wr.cnt    = cnt_inc;
			wr.val_we = 1'b1;
			wr.cnt_we = 1'b1;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			// Load a new result from ST_OUT, otherwise drop the one taken
			if (state_q == ST_OUT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (func_q == FN_CLRALL || !in_range) begin
						state_q <= ST_OUT;
					end else if (func_q == FN_AVG) begin
						state_q <= ST_MAG;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_MAG: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			func_q <= s_axis_tuser[2:0];
			idx_q  <= s_axis_tuser[8:3];
			opnd_q <= s_axis_tdata;
		end
		if (state_q == ST_EXEC) begin
			v_q    <= rd_val;
			c_q    <= rd_cnt;
			diff_q <= opnd_q - rd_val;
			if (func_q == FN_CLRALL || !in_range) begin
				res_q <= '0;
			end else begin
				res_q <= exec_val;
			end
		end
		if (state_q == ST_FIN) begin
			res_q <= fin_val;
		end
		if (state_q == ST_OUT && out_free) begin
			out_data_q <= res_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	scb_bank #(
		.DEPTH (DEPTH)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (s_acc),
		.rd_idx (s_axis_tuser[8:3]),
		.rd_val (rd_val),
		.rd_cnt (rd_cnt),
		.wr     (wr)
	);

	scb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	a_one_txn: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_axis_tready)
		else $error("second transaction accepted while busy");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_busy || div_done || $past(div_start)))
		else $error("waiting on an idle divider");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> m_axis_tvalid)
		else $error("result not presented after load");

endmodule
